/* rtl/complex_integer_alu_defines.svh */
// ----------------------------------------------------------------------------
// Complex integer ALU assertion macros
// Shared concurrent assertion forms for the complex integer ALU.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_INTEGER_ALU_DEFINES_SVH
`define COMPLEX_INTEGER_ALU_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CIA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is high.
`define CIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

/* rtl/cia_pkg.sv */
// ----------------------------------------------------------------------------
// Complex integer ALU package
// Opcodes, pipeline payload type and divider constants.
// ----------------------------------------------------------------------------
package cia_pkg;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } opcode_type;

   // Quotient bits resolved per divider stage, and the number of stages.
   localparam int DIV_BITS           = 32;
   localparam int DIV_STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES          = DIV_BITS / DIV_STEPS_PER_STAGE;

   typedef struct packed {
      logic        is_div;
      logic        dz;
      logic        neg_r;
      logic        neg_i;
      logic [33:0] res_r;
      logic [33:0] res_i;
      logic [31:0] den;
      logic [31:0] rem_r;
      logic [31:0] nq_r;
      logic [31:0] rem_i;
      logic [31:0] nq_i;
   } data_type;

endpackage

/* rtl/complex_integer_alu.sv */
// ----------------------------------------------------------------------------
// Complex integer ALU
// Add, subtract, multiply or divide two 16-bit complex integers.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while the output side is not stalled and
// returns one result beat for each, in order. The path runs through the four
// front-end stages (operand capture, products, sums, magnitudes), the sixteen
// divider stages that each resolve two quotient bits of a 32-bit restoring
// division, and the output register.
// Every operation passes through the whole pipeline so that results leave in
// order. The pipeline advances as a whole whenever the output register is
// empty or its beat is being taken; otherwise everything holds. A divide by
// zero gives zero parts with div_by_zero set.
module complex_integer_alu (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // a_real, a_imag, b_real, b_imag
   input  logic [1:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // res_real, res_imag, four zero bits
   output logic        rsp_tuser    // div_by_zero
);

`include "complex_integer_alu_defines.svh"

   // Global advance: the output register is free or is being emptied.
   logic en;

   logic              stage_valid [cia_pkg::DIV_STAGES+1];
   cia_pkg::data_type stage_data  [cia_pkg::DIV_STAGES+1];

   logic        rsp_tvalid_ff;
   logic [33:0] res_r_ff, res_i_ff, res_r_in, res_i_in;
   logic        dz_ff;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   cia_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid     (req_tvalid),
      .opcode    (cia_pkg::opcode_type'(req_tuser)),
      .a_real    ($signed(req_tdata[15:0])),
      .a_imag    ($signed(req_tdata[31:16])),
      .b_real    ($signed(req_tdata[47:32])),
      .b_imag    ($signed(req_tdata[63:48])),
      .out_valid (stage_valid[0]),
      .out_data  (stage_data[0])
   );

   // The divider: each stage shifts two numerator bits into the partial
   // remainders of both parts and records two quotient bits.
   for (genvar g = 0; g < cia_pkg::DIV_STAGES; g++) begin : g_div
      cia_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (stage_valid[g]),
         .in_data   (stage_data[g]),
         .out_valid (stage_valid[g+1]),
         .out_data  (stage_data[g+1])
      );
   end

   // Result selection: apply the quotient signs for a divide, zero the
   // parts when the divisor is zero, or pass the early result through.
   always_comb begin
      cia_pkg::data_type d;
      d = stage_data[cia_pkg::DIV_STAGES];
      if (d.dz) begin
         res_r_in = '0;
         res_i_in = '0;
      end else if (d.is_div) begin
         res_r_in = d.neg_r ? -{2'b00, d.nq_r} : {2'b00, d.nq_r};
         res_i_in = d.neg_i ? -{2'b00, d.nq_i} : {2'b00, d.nq_i};
      end else begin
         res_r_in = d.res_r;
         res_i_in = d.res_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= stage_valid[cia_pkg::DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_r_ff <= res_r_in;
         res_i_ff <= res_i_in;
         dz_ff    <= stage_data[cia_pkg::DIV_STAGES].dz;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'b0000, res_i_ff, res_r_ff};
   assign rsp_tuser  = dz_ff;

   // A divide-by-zero beat carries zero parts.
   `CIA_ASSERT_IMPL(a_dz_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == 72'd0)
   // A valid item leaving the divider while the pipe advances is presented next.
   `CIA_ASSERT_NEXT(a_out_load, clock, reset, stage_valid[cia_pkg::DIV_STAGES] && en, rsp_tvalid)
   // The divide-by-zero mark is only ever set on a divide.
   `CIA_ASSERT_IMPL(a_dz_div, clock, reset, stage_valid[0] && stage_data[0].dz, stage_data[0].is_div)

endmodule

/* rtl/cia_front.sv */
// ----------------------------------------------------------------------------
// Complex integer ALU front end
// Four stages: operand capture, products, sums, magnitudes for the divider.
// ----------------------------------------------------------------------------
module cia_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                valid,
   input  cia_pkg::opcode_type opcode,
   input  logic signed [15:0]  a_real,
   input  logic signed [15:0]  a_imag,
   input  logic signed [15:0]  b_real,
   input  logic signed [15:0]  b_imag,
   output logic                out_valid,
   output cia_pkg::data_type   out_data
);

   // Stage A: operands.
   logic               va_ff;
   cia_pkg::opcode_type opa_ff;
   logic signed [15:0] ar_ff, ai_ff, br_ff, bi_ff;

   // Stage B: products and add/subtract results.
   logic               vb_ff;
   cia_pkg::opcode_type opb_ff;
   logic signed [31:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bbr_ff, p_bbi_ff;
   logic signed [16:0] s_r_ff, s_i_ff;

   // Stage C: sums.
   logic               vc_ff;
   logic               is_div_c_ff;
   logic signed [33:0] res_r_c_ff, res_i_c_ff;
   logic signed [32:0] num_r_ff, num_i_ff;
   logic [31:0]        den_c_ff;

   // Stage D: divider entry.
   logic               vd_ff;
   cia_pkg::data_type  d_ff, d_in;

   logic signed [16:0] s_r_in, s_i_in;
   logic signed [33:0] res_r_c_in, res_i_c_in;

   always_comb begin
      if (opa_ff == cia_pkg::OP_SUB) begin
         s_r_in = {ar_ff[15], ar_ff} - {br_ff[15], br_ff};
         s_i_in = {ai_ff[15], ai_ff} - {bi_ff[15], bi_ff};
      end else begin
         s_r_in = {ar_ff[15], ar_ff} + {br_ff[15], br_ff};
         s_i_in = {ai_ff[15], ai_ff} + {bi_ff[15], bi_ff};
      end
   end

   always_comb begin
      if (opb_ff == cia_pkg::OP_MUL) begin
         res_r_c_in = {{2{p_rr_ff[31]}}, p_rr_ff} - {{2{p_ii_ff[31]}}, p_ii_ff};
         res_i_c_in = {{2{p_ri_ff[31]}}, p_ri_ff} + {{2{p_ir_ff[31]}}, p_ir_ff};
      end else begin
         res_r_c_in = {{17{s_r_ff[16]}}, s_r_ff};
         res_i_c_in = {{17{s_i_ff[16]}}, s_i_ff};
      end
   end

   always_comb begin
      d_in        = '0;
      d_in.is_div = is_div_c_ff;
      d_in.dz     = is_div_c_ff && (den_c_ff == 32'd0);
      d_in.neg_r  = num_r_ff[32];
      d_in.neg_i  = num_i_ff[32];
      d_in.res_r  = res_r_c_ff;
      d_in.res_i  = res_i_c_ff;
      d_in.den    = den_c_ff;
      d_in.nq_r   = num_r_ff[32] ? 32'(-num_r_ff) : num_r_ff[31:0];
      d_in.nq_i   = num_i_ff[32] ? 32'(-num_i_ff) : num_i_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (en) begin
         va_ff <= valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         opa_ff      <= opcode;
         ar_ff       <= a_real;
         ai_ff       <= a_imag;
         br_ff       <= b_real;
         bi_ff       <= b_imag;
         opb_ff      <= opa_ff;
         p_rr_ff     <= ar_ff * br_ff;
         p_ii_ff     <= ai_ff * bi_ff;
         p_ri_ff     <= ar_ff * bi_ff;
         p_ir_ff     <= ai_ff * br_ff;
         p_bbr_ff    <= br_ff * br_ff;
         p_bbi_ff    <= bi_ff * bi_ff;
         s_r_ff      <= s_r_in;
         s_i_ff      <= s_i_in;
         is_div_c_ff <= (opb_ff == cia_pkg::OP_DIV);
         res_r_c_ff  <= res_r_c_in;
         res_i_c_ff  <= res_i_c_in;
         num_r_ff    <= {p_rr_ff[31], p_rr_ff} + {p_ii_ff[31], p_ii_ff};
         num_i_ff    <= {p_ir_ff[31], p_ir_ff} - {p_ri_ff[31], p_ri_ff};
         den_c_ff    <= p_bbr_ff + p_bbi_ff;
         d_ff        <= d_in;
      end
   end

   assign out_valid = vd_ff;
   assign out_data  = d_ff;

endmodule

/* rtl/cia_div_stage.sv */
// ----------------------------------------------------------------------------
// Complex integer ALU divider stage
// Resolves two restoring-division quotient bits for both parts.
// ----------------------------------------------------------------------------
module cia_div_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  cia_pkg::data_type in_data,
   output logic              out_valid,
   output cia_pkg::data_type out_data
);

   logic              valid_ff;
   cia_pkg::data_type data_ff, data_in;

   always_comb begin
      logic [32:0] tr;
      logic [32:0] ti;
      data_in = in_data;
      for (int s = 0; s < cia_pkg::DIV_STEPS_PER_STAGE; s++) begin
         tr = {data_in.rem_r, data_in.nq_r[31]};
         ti = {data_in.rem_i, data_in.nq_i[31]};
         data_in.nq_r = {data_in.nq_r[30:0], (tr >= {1'b0, data_in.den})};
         data_in.nq_i = {data_in.nq_i[30:0], (ti >= {1'b0, data_in.den})};
         if (data_in.nq_r[0]) begin
            tr = tr - {1'b0, data_in.den};
         end
         if (data_in.nq_i[0]) begin
            ti = ti - {1'b0, data_in.den};
         end
         data_in.rem_r = tr[31:0];
         data_in.rem_i = ti[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
